[rtl/ppbe_pkg.sv]
package ppbe_pkg;

  localparam int unsigned RequestLengthDef  = 4;
  localparam int unsigned ResponseLengthDef = 8;

  // response bytes that are decoded: type, pad, two button bytes, four axes
  localparam int unsigned FrameBytes  = 8;
  localparam int unsigned FrameIdxW   = 3;
  localparam int unsigned MinOkBytes  = 4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgPortSelect    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDeviceAddress = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPollCommand   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRumbleFirst   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRumbleSecond  = 3'd4;

  localparam logic [7:0] DeviceAddressRst = 8'd1;
  localparam logic [7:0] PollCommandRst   = 8'd66;

  localparam logic FuncStart    = 1'b0;
  localparam logic FuncExchange = 1'b1;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 96;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhAddr = 2'd1,
    PhData = 2'd2
  } phase_e;

  typedef struct packed {
    logic       port_select;
    logic [7:0] device_address;
    logic [7:0] poll_command;
    logic [7:0] rumble_first;
    logic [7:0] rumble_second;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic ok;
  } frame_stat_t;

  typedef logic [FrameBytes-1:0][7:0] store_t;
  typedef logic [3:0][7:0] axes_t;

endpackage

[rtl/ppbe_cfg.sv]
module ppbe_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ppbe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ppbe_pkg::CfgDataW-1:0]      cfg_data_i,
  output ppbe_pkg::cfg_t                     cfg_o
);

  ppbe_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ppbe_pkg::CfgPortSelect:    cfg_d.port_select    = cfg_data_i[0];
        ppbe_pkg::CfgDeviceAddress: cfg_d.device_address = cfg_data_i;
        ppbe_pkg::CfgPollCommand:   cfg_d.poll_command   = cfg_data_i;
        ppbe_pkg::CfgRumbleFirst:   cfg_d.rumble_first   = cfg_data_i;
        ppbe_pkg::CfgRumbleSecond:  cfg_d.rumble_second  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port_select    <= 1'b0;
      cfg_q.device_address <= ppbe_pkg::DeviceAddressRst;
      cfg_q.poll_command   <= ppbe_pkg::PollCommandRst;
      cfg_q.rumble_first   <= 8'd0;
      cfg_q.rumble_second  <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ppbe_frame.sv]
module ppbe_frame #(
  parameter int unsigned RequestLength  = ppbe_pkg::RequestLengthDef,
  parameter int unsigned ResponseLength = ppbe_pkg::ResponseLengthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  func_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  acked_i,
  input  ppbe_pkg::cfg_t        cfg_i,
  output logic [7:0]            tx_byte_o,
  output logic                  send_byte_o,
  output ppbe_pkg::frame_stat_t stat_o,
  output ppbe_pkg::store_t      store_o
);

  localparam int unsigned CntW = $clog2(ResponseLength + 1);

  ppbe_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  count_q, count_d;
  ppbe_pkg::store_t store_q, store_d;
  logic             done;

  function automatic logic [7:0] req_byte(input logic [CntW-1:0] idx,
                                          input ppbe_pkg::cfg_t cfg);
    logic [7:0] b;
    b = 8'd0;
    if (32'(idx) < RequestLength) begin
      unique case (32'(idx))
        0:       b = cfg.poll_command;
        2:       b = cfg.rumble_first;
        3:       b = cfg.rumble_second;
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    store_d     = store_q;
    tx_byte_o   = 8'd0;
    send_byte_o = 1'b0;
    done        = 1'b0;
    if (func_i == ppbe_pkg::FuncStart) begin
      store_d     = '0;
      count_d     = '0;
      phase_d     = ppbe_pkg::PhAddr;
      tx_byte_o   = cfg_i.device_address;
      send_byte_o = 1'b1;
    end else begin
      unique case (phase_q)
        ppbe_pkg::PhAddr: begin
          if (!acked_i || 32'(count_q) >= ResponseLength) begin
            done = 1'b1;
          end else begin
            phase_d     = ppbe_pkg::PhData;
            tx_byte_o   = req_byte(count_q, cfg_i);
            send_byte_o = 1'b1;
          end
        end
        ppbe_pkg::PhData: begin
          if (32'(count_q) < ppbe_pkg::FrameBytes) begin
            store_d[count_q[ppbe_pkg::FrameIdxW-1:0]] = rx_byte_i;
          end
          count_d = CntW'(count_q + 1'b1);
          if (!acked_i || 32'(count_d) >= ResponseLength) begin
            done = 1'b1;
          end else begin
            tx_byte_o   = req_byte(count_d, cfg_i);
            send_byte_o = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (done) begin
      phase_d = ppbe_pkg::PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ppbe_pkg::PhIdle;
      count_q <= '0;
      store_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      store_q <= store_d;
    end
  end

  assign stat_o.done = done;
  assign stat_o.ok   = done && (32'(count_d) >= ppbe_pkg::MinOkBytes);
  assign store_o     = store_d;

endmodule

[rtl/ppbe_decode.sv]
module ppbe_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ppbe_pkg::frame_stat_t stat_i,
  input  ppbe_pkg::store_t      store_i,
  output logic [3:0]            device_type_o,
  output logic [15:0]           buttons_o,
  output logic [15:0]           pressed_o,
  output logic [15:0]           released_o,
  output ppbe_pkg::axes_t       axes_o
);

  logic [3:0]      type_q, type_d;
  logic [15:0]     buttons_q, buttons_d;
  ppbe_pkg::axes_t axes_q, axes_d;

  // buttons output is the newly decoded mask on a good frame, else the latched buttons
  always_comb begin
    type_d     = type_q;
    buttons_d  = buttons_q;
    axes_d     = axes_q;
    pressed_o  = 16'd0;
    released_o = 16'd0;
    if (stat_i.ok) begin
      type_d     = store_i[0][7:4];
      buttons_d  = {store_i[3], store_i[2]} ^ 16'hffff;
      axes_d     = {store_i[7], store_i[6], store_i[5], store_i[4]};
      pressed_o  = buttons_d & ~buttons_q;
      released_o = buttons_q & ~buttons_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= '0;
      buttons_q <= '0;
      axes_q    <= '0;
    end else if (en_i) begin
      type_q    <= type_d;
      buttons_q <= buttons_d;
      axes_q    <= axes_d;
    end
  end

  assign device_type_o = type_d;
  assign buttons_o     = buttons_d;
  assign axes_o        = axes_d;

endmodule

[rtl/pad_poll_and_button_edges.sv]
// A transaction's result is registered and shows on the master side the next cycle.
// Throughput: one transaction per cycle while the master side takes results; apart
// from config writes, state only updates in the pass from input to result register.
// Reset (rst_ni low, asynchronous): frame idle, response store and latched pad
// state cleared, registers at defaults (address 1, command 66), no result pending.
module pad_poll_and_button_edges #(
  parameter int unsigned RequestLength  = ppbe_pkg::RequestLengthDef,
  parameter int unsigned ResponseLength = ppbe_pkg::ResponseLengthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] rx_byte, [8] acked, [15:9] zero
  input  logic [ppbe_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] tx_byte, [8] send_byte, [9] poll_ok, [13:10] device_type,
  // [29:14] buttons, [45:30] pressed, [61:46] released, [69:62] right_x,
  // [77:70] right_y, [85:78] left_x, [93:86] left_y, [95:94] zero
  output logic [ppbe_pkg::OutDataW-1:0]     m_axis_tdata,
  // frame_done
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [ppbe_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ppbe_pkg::CfgDataW-1:0]     cfg_data_i
);

  ppbe_pkg::cfg_t        cfg;
  ppbe_pkg::frame_stat_t stat;
  ppbe_pkg::store_t      store;
  ppbe_pkg::axes_t       axes;
  logic                  s_hs;
  logic [7:0]            tx_byte;
  logic                  send_byte;
  logic [3:0]            device_type;
  logic [15:0]           buttons, pressed, released;

  logic                          m_valid_q, m_valid_d;
  logic [ppbe_pkg::OutDataW-1:0] m_data_q;
  logic                          m_last_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  ppbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppbe_frame #(
    .RequestLength  (RequestLength),
    .ResponseLength (ResponseLength)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s_hs),
    .func_i      (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .acked_i     (s_axis_tdata[8]),
    .cfg_i       (cfg),
    .tx_byte_o   (tx_byte),
    .send_byte_o (send_byte),
    .stat_o      (stat),
    .store_o     (store)
  );

  ppbe_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (s_hs),
    .stat_i        (stat),
    .store_i       (store),
    .device_type_o (device_type),
    .buttons_o     (buttons),
    .pressed_o     (pressed),
    .released_o    (released),
    .axes_o        (axes)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (s_hs) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      m_data_q <= {2'b00, axes[3], axes[2], axes[1], axes[0], released, pressed,
                   buttons, device_type, stat.ok, send_byte, tx_byte};
      m_last_q <= stat.done;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[8])
    else $error("frame end with another byte requested");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tlast)
    else $error("poll ok outside frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[45:30] & m_axis_tdata[61:46]) == 16'd0)
    else $error("button both pressed and released");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && s_axis_tuser == ppbe_pkg::FuncStart |=> m_axis_tvalid && !m_axis_tlast)
    else $error("start transaction did not yield an open frame result");
`endif

endmodule
